### hw/rtl/ewv_pkg.sv
package ewv_pkg;

    localparam int WINDOW = 16;
    localparam int LOG_W  = $clog2(WINDOW);
    localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    localparam int CNT_W  = 32;
    localparam int MS_W   = 16;
    localparam int VEL_W  = 48;

    // window sums are held exactly
    localparam int TICK_W = CNT_W + LOG_W;
    localparam int TIME_W = MS_W + LOG_W;

    // 256000 = 125 * 2^11: multiply by the odd part, append the zeros
    localparam int SCALE_ODD   = 125;
    localparam int SCALE_ODD_W = 7;
    localparam int SCALE_SHIFT = 11;

    localparam int MAG_W  = TICK_W;
    localparam int PROD_W = MAG_W + SCALE_ODD_W;
    localparam int NUM_W  = PROD_W + SCALE_SHIFT;

    localparam logic [NUM_W-1:0] Q_NEG_MAX = NUM_W'(1) << (VEL_W - 1);
    localparam logic [NUM_W-1:0] Q_POS_MAX = Q_NEG_MAX - NUM_W'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_START,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [CNT_W-1:0] delta;
        logic [MS_W-1:0]  ms;
    } t_entry;

    typedef struct packed {
        logic in_ready;
        logic mem_we;
        logic div_start;
        logic out_load;
    } t_ctl;

endpackage

### hw/rtl/ewv_if.sv
interface ewv_smp_if;
    logic                               valid;
    logic                               ready;
    logic signed [ewv_pkg::CNT_W-1:0]   encoder_count;
    logic        [ewv_pkg::MS_W-1:0]    elapsed_ms;
    logic                               clear_position;

    modport source (output valid, encoder_count, elapsed_ms, clear_position, input ready);
    modport sink   (input valid, encoder_count, elapsed_ms, clear_position, output ready);
endinterface

interface ewv_vel_if;
    logic                               valid;
    logic                               ready;
    logic signed [ewv_pkg::VEL_W-1:0]   velocity_ticks_per_s;
    logic signed [ewv_pkg::CNT_W-1:0]   position_count;
    logic                               no_time_flag;

    modport source (output valid, velocity_ticks_per_s, position_count, no_time_flag,
                    input ready);
    modport sink   (input valid, velocity_ticks_per_s, position_count, no_time_flag,
                    output ready);
endinterface

### hw/rtl/ewv_div.sv
module ewv_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ewv_pkg::NUM_W-1:0]   i_num,
    input  logic [ewv_pkg::TIME_W-1:0]  i_den,
    output logic                        o_done,
    output logic [ewv_pkg::NUM_W-1:0]   o_quot
);
    import ewv_pkg::*;

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_cnt;
    logic [TIME_W-1:0]   r_rem;
    logic [NUM_W-1:0]    r_quo;
    logic [TIME_W-1:0]   r_den;

    logic [TIME_W:0]     rem_sh;
    logic                q_bit;
    logic [TIME_W:0]     rem_sub;

    // restoring divide, one quotient bit per cycle; numerator shifts out of r_quo
    always_comb begin
        rem_sh  = {r_rem, r_quo[NUM_W-1]};
        q_bit   = (rem_sh >= {1'b0, r_den});
        rem_sub = rem_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= q_bit ? rem_sub[TIME_W-1:0] : rem_sh[TIME_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], q_bit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

`ifndef ASSERT_OFF
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start)
        else $error("divider restarted while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && !r_busy)
        else $error("divider done without a finished run");
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> i_den != '0)
        else $error("divider started with zero divisor");
`endif

endmodule

### hw/rtl/encoder_window_velocity.sv
// Moving-window encoder velocity. Each accepted sample word (count, elapsed ms, clear)
// yields one result word: the velocity over the last WINDOW samples in ticks/s with
// 8 fraction bits (window tick sum * 1000 / window time sum, truncated toward zero,
// saturated to 48 bits), the sample's count, and a flag when the window time sum is
// zero (velocity 0). Deltas and times live in a one-port ring RAM that is read,
// updated and written back per sample; empty slots read as zero. One sample is in
// flight at a time; its velocity comes from the one-bit-per-cycle restoring divider,
// which a zero time sum skips. A finished result waits in the output register while
// the next sample is taken.
module encoder_window_velocity (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ewv_smp_if.sink     i_smp,
    ewv_vel_if.source   o_vel
);
    import ewv_pkg::*;

    t_state                     r_state;
    t_state                     n_state;
    t_ctl                       ctl;

    t_entry                     mem [WINDOW];
    t_entry                     r_rd;
    logic                       r_rd_vld;
    t_entry                     old;
    logic [WINDOW-1:0]          r_vld;
    logic [PTR_W-1:0]           r_ptr;

    logic [CNT_W-1:0]           r_prev;
    logic [CNT_W-1:0]           r_delta;
    logic [CNT_W-1:0]           r_count;
    logic [MS_W-1:0]            r_ms;

    logic signed [TICK_W-1:0]   r_tick;
    logic [TIME_W-1:0]          r_time;
    logic                       r_neg;
    logic [MAG_W-1:0]           mag;
    logic [NUM_W-1:0]           r_num;

    logic                       div_done;
    logic [NUM_W-1:0]           div_quot;
    logic [NUM_W-1:0]           q_clamp;
    logic [VEL_W-1:0]           vel;

    logic                       r_out_valid;
    logic [VEL_W-1:0]           r_out_vel;
    logic [CNT_W-1:0]           r_out_pos;
    logic                       r_out_flag;

    logic                       in_acc;
    logic                       out_free;

    assign in_acc   = i_smp.valid && i_smp.ready;
    assign out_free = !r_out_valid || o_vel.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_smp.valid) n_state = S_READ;
            S_READ:  n_state = S_MUL;
            S_MUL:   n_state = (r_time == '0) ? S_DONE : S_START;
            S_START: n_state = S_DIV;
            S_DIV:   if (div_done) n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        ctl           = '0;
        ctl.in_ready  = (r_state == S_IDLE);
        ctl.mem_we    = (r_state == S_READ);
        ctl.div_start = (r_state == S_START);
        ctl.out_load  = (r_state == S_DONE) && out_free;
    end

    assign i_smp.ready = ctl.in_ready;

    // ring RAM, read data registered
    always_ff @(posedge i_clk) begin
        if (ctl.mem_we) begin
            mem[r_ptr] <= '{delta: r_delta, ms: r_ms};
        end
        r_rd     <= mem[r_ptr];
        r_rd_vld <= r_vld[r_ptr];
    end

    assign old = r_rd_vld ? r_rd : '0;
    assign mag = r_tick[TICK_W-1] ? MAG_W'(-r_tick) : MAG_W'(r_tick);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ptr       <= '0;
            r_vld       <= '0;
            r_prev      <= '0;
            r_tick      <= '0;
            r_time      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_prev <= i_smp.encoder_count;
            end
            if (ctl.mem_we) begin
                r_tick <= r_tick + TICK_W'($signed(r_delta)) - TICK_W'($signed(old.delta));
                r_time <= r_time + TIME_W'(r_ms) - TIME_W'(old.ms);
                r_vld[r_ptr] <= 1'b1;
                r_ptr <= (r_ptr == PTR_W'(WINDOW - 1)) ? '0 : r_ptr + PTR_W'(1);
            end
            if (ctl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_vel.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_delta <= i_smp.encoder_count - (i_smp.clear_position ? '0 : r_prev);
            r_count <= i_smp.encoder_count;
            r_ms    <= i_smp.elapsed_ms;
        end
        if (r_state == S_MUL) begin
            r_neg <= r_tick[TICK_W-1];
            r_num <= {PROD_W'(mag) * PROD_W'(SCALE_ODD), SCALE_SHIFT'(0)};
        end
        if (ctl.out_load) begin
            r_out_vel  <= vel;
            r_out_pos  <= r_count;
            r_out_flag <= (r_time == '0);
        end
    end

    ewv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ctl.div_start),
        .i_num   (r_num),
        .i_den   (r_time),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // saturate magnitude, then apply sign; zero when the time sum is zero
    always_comb begin
        if (r_neg) begin
            q_clamp = (div_quot > Q_NEG_MAX) ? Q_NEG_MAX : div_quot;
            vel     = VEL_W'(NUM_W'(0) - q_clamp);
        end else begin
            q_clamp = (div_quot > Q_POS_MAX) ? Q_POS_MAX : div_quot;
            vel     = VEL_W'(q_clamp);
        end
        if (r_time == '0) begin
            vel = '0;
        end
    end

    assign o_vel.valid                = r_out_valid;
    assign o_vel.velocity_ticks_per_s = r_out_vel;
    assign o_vel.position_count       = r_out_pos;
    assign o_vel.no_time_flag         = r_out_flag;

`ifndef ASSERT_OFF
    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state == S_READ && !i_smp.ready)
        else $error("accepted word did not start a ring read");
    a_no_time_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vel.valid && o_vel.no_time_flag |-> o_vel.velocity_ticks_per_s == '0)
        else $error("nonzero velocity with zero time sum");
    a_div_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.div_start |-> r_time != '0)
        else $error("divide started on empty time sum");
    a_ring_write_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.mem_we |=> r_vld[$past(r_ptr)])
        else $error("ring slot not marked after write");
`endif

endmodule

### tb/encoder_window_velocity_tb.sv
module encoder_window_velocity_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ewv_pkg::WINDOW;
    import ewv_pkg::CNT_W;
    import ewv_pkg::MS_W;
    import ewv_pkg::VEL_W;

    localparam int          CYCLE_LIMIT = 400000;
    localparam int          RANDOM_WORDS = 600;
    localparam int          DRAIN_CYCLES = 120;
    // ticks/ms -> ticks/s with 8 fraction bits
    localparam logic [63:0] TICKS_MS_TO_Q8 = 64'd256000;
    localparam logic [63:0] SAT_NEG = 64'd1 << (VEL_W - 1);
    localparam logic [63:0] SAT_POS = SAT_NEG - 64'd1;

    typedef struct packed {
        logic signed [VEL_W-1:0] velocity;
        logic signed [CNT_W-1:0] position;
        logic                    no_time;
    } vel_word_t;

    class velocity_scoreboard;
        logic        [CNT_W-1:0] prev_count;
        logic signed [CNT_W-1:0] delta_ring [WINDOW];
        logic        [MS_W-1:0]  ms_ring [WINDOW];
        longint                  tick_sum;
        int unsigned             time_sum;
        int                      slot;
        vel_word_t               pending_velocity [$];
        int                      errors;

        function new();
            prev_count = '0;
            foreach (delta_ring[k]) begin
                delta_ring[k] = '0;
                ms_ring[k] = '0;
            end
            tick_sum = 0;
            time_sum = 0;
            slot = 0;
            errors = 0;
        endfunction

        function int pending();
            return pending_velocity.size();
        endfunction

        // tick_sum * 256000 / time_sum, truncated toward zero, clipped to 48 bits
        function logic [VEL_W-1:0] window_velocity();
            logic        neg;
            logic [63:0] mag;
            logic [63:0] q;
            logic [63:0] v;
            neg = tick_sum < 0;
            mag = neg ? 64'(-tick_sum) : 64'(tick_sum);
            q = (mag * TICKS_MS_TO_Q8) / 64'(time_sum);
            if (neg) begin
                if (q > SAT_NEG) q = SAT_NEG;
                v = 64'd0 - q;
            end else begin
                if (q > SAT_POS) q = SAT_POS;
                v = q;
            end
            return v[VEL_W-1:0];
        endfunction

        function void note_sample(logic [CNT_W-1:0] count, logic [MS_W-1:0] ms, logic clr);
            logic signed [CNT_W-1:0] delta;
            vel_word_t               w;
            delta = count - (clr ? '0 : prev_count);
            prev_count = count;
            tick_sum = tick_sum + longint'(delta) - longint'(delta_ring[slot]);
            time_sum = time_sum + ms - ms_ring[slot];
            delta_ring[slot] = delta;
            ms_ring[slot] = ms;
            slot = (slot + 1) % WINDOW;
            w.position = count;
            w.no_time = (time_sum == 0);
            w.velocity = w.no_time ? '0 : window_velocity();
            pending_velocity.insert(pending_velocity.size(), w);
        endfunction

        function void check_result(vel_word_t got);
            vel_word_t exp_w;
            if (pending_velocity.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word: vel=%0d pos=%0d no_time=%0b",
                             got.velocity, got.position, got.no_time);
                return;
            end
            exp_w = pending_velocity.pop_front();
            if (got.velocity !== exp_w.velocity || got.position !== exp_w.position ||
                    got.no_time !== exp_w.no_time) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: vel exp %0d got %0d, pos exp %0d got %0d, ",
                              "no_time exp %0b got %0b"},
                             exp_w.velocity, got.velocity, exp_w.position, got.position,
                             exp_w.no_time, got.no_time);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   idle_en;
    int   cycle_count;

    velocity_scoreboard sb;

    ewv_smp_if smp();
    ewv_vel_if vel();

    encoder_window_velocity DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp),
        .o_vel   (vel)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // result side: random stall bursts while idling is on
    initial begin
        vel.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (idle_en && $urandom_range(0, 5) == 0) begin
                vel.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                vel.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && vel.valid && vel.ready)
            sb.check_result(vel_word_t'{vel.velocity_ticks_per_s, vel.position_count,
                                        vel.no_time_flag});
    end

    // holds the word until taken; valid stays high for back-to-back words
    task automatic send_sample(input logic [CNT_W-1:0] count, input logic [MS_W-1:0] ms,
                               input logic clr);
        smp.valid <= 1'b1;
        smp.encoder_count <= count;
        smp.elapsed_ms <= ms;
        smp.clear_position <= clr;
        do @(posedge i_clk); while (!smp.ready);
        sb.note_sample(count, ms, clr);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            smp.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic hold_until_drained();
        smp.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic run_random_words();
        logic [CNT_W-1:0] shaft;
        logic [MS_W-1:0]  ms;
        logic             clr;
        int               pick;
        int               n;
        shaft = '0;
        n = 0;
        while (n < RANDOM_WORDS) begin
            idle_en = !(n >= 200 && n < 250) && n < 500;
            if (n == 300)
                hold_until_drained();
            if (n % 150 == 75) begin
                // long zero-time run empties the time window
                repeat (17) begin
                    shaft = shaft + 32'($urandom_range(0, 200)) - 32'd100;
                    send_sample(shaft, '0, 1'b0);
                    n++;
                end
            end else begin
                pick = $urandom_range(0, 99);
                clr = ($urandom_range(0, 29) == 0);
                if (pick < 70) begin
                    shaft = shaft + 32'($urandom_range(0, 6000)) - 32'd3000;
                    ms = MS_W'($urandom_range(1, 40));
                end else if (pick < 80) begin
                    shaft = shaft + 32'($urandom_range(0, 6000)) - 32'd3000;
                    ms = '0;
                end else if (pick < 88) begin
                    shaft = $urandom;
                    ms = MS_W'($urandom_range(0, 65535));
                    clr = 1'($urandom_range(0, 1));
                end else if (pick < 95) begin
                    // fast spin, tiny window time: pushes toward saturation
                    shaft = shaft + 32'($urandom_range(0, 1 << 25)) - 32'(1 << 24);
                    ms = MS_W'($urandom_range(0, 3));
                end else begin
                    shaft = shaft + 32'($urandom_range(0, 100)) - 32'd50;
                    ms = MS_W'($urandom_range(0, 65535));
                    clr = 1'($urandom_range(0, 1));
                end
                send_sample(shaft, ms, clr);
                n++;
            end
        end
    endtask

    initial begin
        sb = new();
        idle_en = 1'b1;
        i_rst_n <= 1'b0;
        smp.valid <= 1'b0;
        smp.encoder_count <= '0;
        smp.elapsed_ms <= '0;
        smp.clear_position <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty window: zero time sum
        send_sample(32'd0, 16'd0, 1'b0);
        // clear with most negative count, 1 ms: negative clip
        send_sample(32'h8000_0000, 16'd1, 1'b1);
        send_sample(32'h7FFF_FFFF, 16'd0, 1'b1);
        // count wraps from max to min
        send_sample(32'h8000_0000, 16'd0, 1'b0);
        // clear with max count: positive clip
        send_sample(32'h7FFF_FFFF, 16'd0, 1'b1);
        send_sample(32'h7FFF_FFFF, 16'hFFFF, 1'b0);
        // flush the window with zero-time words; the last one sees time sum zero
        repeat (16) send_sample(32'h7FFF_FFFF, 16'd0, 1'b0);
        send_sample(32'd5, 16'd3, 1'b0);
        send_sample(32'hFFFF_FFF9, 16'hFFFF, 1'b0);
        send_sample(32'hFFFF_FFF9, 16'hFFFF, 1'b1);

        run_random_words();

        smp.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
